// File: hdl/m4me_pkg.sv
// shared codes, widths and pipeline types of the 4x4 matrix multiply engine
package m4me_pkg;

   localparam int unsigned DIM      = 4;
   localparam int unsigned IDX_W    = 2;
   localparam int unsigned CNT_W    = 4;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned PROD_W   = 2 * DATA_W;
   localparam int unsigned PAIR_W   = PROD_W + 1;
   localparam int unsigned SUM_W    = PROD_W + 2;

   localparam logic [1:0] KIND_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] KIND_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] KIND_PRODUCT    = 2'd2;
   localparam logic [1:0] KIND_TRANSFORM  = 2'd3;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   // tag that travels with each word through the pipeline
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last;
   } meta_type;

   typedef logic signed [DATA_W-1:0] word_type;

endpackage

// File: hdl/mat4_multiply_engine.sv
// 4x4 matrix multiply and matrix-vector transform in signed Q16.16
//
// The engine holds a left and a right 4x4 matrix in lane-banked memories: the left matrix is
// banked by column and addressed by row, the right by row and addressed by column, so one read
// returns a full left row and a full right column. Load words write one element. A product
// word issues 16 dot products, one per cycle while the pipeline is not frozen, and a transform
// word issues 4 (the right column is replaced by the vector carried in the word). Each dot
// product passes a registered memory read, four parallel 32x32 multipliers, a pair-add stage
// and a final add with truncation and saturation into the output register; results follow one
// per cycle while rsp_ready stays high, and a low rsp_ready while a result is held freezes the
// whole pipeline. A new word is taken as soon as all reads of the previous one have been
// issued, while its results still drain, so a product or transform word holds the input until
// its last read issues, later if rsp_ready freezes the pipeline; a load word holds it until taken.
// After reset both matrices read as zero; there is no clearing pass.
module mat4_multiply_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_kind,
   input  logic [m4me_pkg::IDX_W-1:0]     req_row_sel,
   input  logic [m4me_pkg::IDX_W-1:0]     req_col_sel,
   input  logic signed [m4me_pkg::DATA_W-1:0] req_element_value,
   input  logic signed [m4me_pkg::DATA_W-1:0] req_vec_x,
   input  logic signed [m4me_pkg::DATA_W-1:0] req_vec_y,
   input  logic signed [m4me_pkg::DATA_W-1:0] req_vec_z,
   input  logic signed [m4me_pkg::DATA_W-1:0] req_vec_w,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [m4me_pkg::IDX_W-1:0]     rsp_out_row,
   output logic [m4me_pkg::IDX_W-1:0]     rsp_out_col,
   output logic signed [m4me_pkg::DATA_W-1:0] rsp_out_value,
   output logic                           rsp_out_last
);

   // lane-banked storage, [lane][address]
   m4me_pkg::word_type left_mem  [m4me_pkg::DIM][m4me_pkg::DIM];
   m4me_pkg::word_type right_mem [m4me_pkg::DIM][m4me_pkg::DIM];

   logic [m4me_pkg::DIM-1:0][m4me_pkg::DIM-1:0] left_vld_ff, left_vld_in;
   logic [m4me_pkg::DIM-1:0][m4me_pkg::DIM-1:0] right_vld_ff, right_vld_in;

   logic                         busy_ff, busy_in;
   logic                         xf_ff, xf_in;
   logic [m4me_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   m4me_pkg::word_type           vec_ff [m4me_pkg::DIM];

   m4me_pkg::meta_type           s1_meta_ff, s1_meta_in;
   m4me_pkg::meta_type           s2_meta_ff;
   m4me_pkg::meta_type           s3_meta_ff;
   m4me_pkg::word_type           s1_a_ff [m4me_pkg::DIM];
   m4me_pkg::word_type           s1_b_ff [m4me_pkg::DIM];
   logic signed [m4me_pkg::PROD_W-1:0] s2_prod_ff [m4me_pkg::DIM];
   logic signed [m4me_pkg::PAIR_W-1:0] s3_pair_ff [2];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [m4me_pkg::IDX_W-1:0]   rsp_row_ff, rsp_col_ff;
   logic                         rsp_last_ff;
   m4me_pkg::word_type           rsp_value_ff, rsp_value_in;

   logic                         accept, load_left, load_right, start;
   logic                         adv, issue, issue_last;
   logic [m4me_pkg::IDX_W-1:0]   left_addr, right_addr;
   logic signed [m4me_pkg::SUM_W-1:0] sum;

   assign accept     = req_valid && req_ready;
   assign load_left  = accept && (req_kind == m4me_pkg::KIND_LOAD_LEFT);
   assign load_right = accept && (req_kind == m4me_pkg::KIND_LOAD_RIGHT);
   assign start      = accept && ((req_kind == m4me_pkg::KIND_PRODUCT) ||
                                  (req_kind == m4me_pkg::KIND_TRANSFORM));

   // whole pipeline moves together whenever the output register can take a word
   assign adv   = !rsp_valid_ff || rsp_ready;
   assign issue = busy_ff && adv;

   assign left_addr  = xf_ff ? cnt_ff[m4me_pkg::IDX_W-1:0] : cnt_ff[m4me_pkg::CNT_W-1:2];
   assign right_addr = cnt_ff[m4me_pkg::IDX_W-1:0];
   assign issue_last = xf_ff ? (cnt_ff[m4me_pkg::IDX_W-1:0] == 2'd3) : (cnt_ff == 4'd15);

   assign req_ready = !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      xf_in        = xf_ff;
      cnt_in       = cnt_ff;
      left_vld_in  = left_vld_ff;
      right_vld_in = right_vld_ff;
      if (start) begin
         busy_in = 1'b1;
         xf_in   = (req_kind == m4me_pkg::KIND_TRANSFORM);
         cnt_in  = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + 4'd1;
         if (issue_last) begin
            busy_in = 1'b0;
         end
      end
      if (load_left) begin
         left_vld_in[req_col_sel][req_row_sel] = 1'b1;
      end
      if (load_right) begin
         right_vld_in[req_row_sel][req_col_sel] = 1'b1;
      end
   end

   always_comb begin
      s1_meta_in       = '0;
      s1_meta_in.valid = issue;
      s1_meta_in.row   = left_addr;
      s1_meta_in.col   = xf_ff ? '0 : right_addr;
      s1_meta_in.last  = issue_last;
   end

   // final add, drop the fraction bits and clamp to the 32-bit range
   always_comb begin
      sum = m4me_pkg::SUM_W'(s3_pair_ff[0]) + m4me_pkg::SUM_W'(s3_pair_ff[1]);
      if (sum[m4me_pkg::SUM_W-1:m4me_pkg::FRAC_W+m4me_pkg::DATA_W-1] == '0 ||
          sum[m4me_pkg::SUM_W-1:m4me_pkg::FRAC_W+m4me_pkg::DATA_W-1] == '1) begin
         rsp_value_in = sum[m4me_pkg::FRAC_W+m4me_pkg::DATA_W-1:m4me_pkg::FRAC_W];
      end else if (sum[m4me_pkg::SUM_W-1]) begin
         rsp_value_in = m4me_pkg::Q_MIN;
      end else begin
         rsp_value_in = m4me_pkg::Q_MAX;
      end
      rsp_valid_in = adv ? s3_meta_ff.valid : rsp_valid_ff;
   end

   // memories: one-element write, one-row or one-column read; unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (load_left) begin
         left_mem[req_col_sel][req_row_sel] <= req_element_value;
      end
      if (load_right) begin
         right_mem[req_row_sel][req_col_sel] <= req_element_value;
      end
      if (adv) begin
         for (int k = 0; k < m4me_pkg::DIM; k++) begin
            s1_a_ff[k] <= left_vld_ff[k][left_addr] ? left_mem[k][left_addr] : '0;
            if (xf_ff) begin
               s1_b_ff[k] <= vec_ff[k];
            end else begin
               s1_b_ff[k] <= right_vld_ff[k][right_addr] ? right_mem[k][right_addr] : '0;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         vec_ff[0] <= req_vec_x;
         vec_ff[1] <= req_vec_y;
         vec_ff[2] <= req_vec_z;
         vec_ff[3] <= req_vec_w;
      end
      if (adv) begin
         for (int k = 0; k < m4me_pkg::DIM; k++) begin
            s2_prod_ff[k] <= m4me_pkg::PROD_W'(s1_a_ff[k]) * m4me_pkg::PROD_W'(s1_b_ff[k]);
         end
         s3_pair_ff[0] <= m4me_pkg::PAIR_W'(s2_prod_ff[0]) + m4me_pkg::PAIR_W'(s2_prod_ff[1]);
         s3_pair_ff[1] <= m4me_pkg::PAIR_W'(s2_prod_ff[2]) + m4me_pkg::PAIR_W'(s2_prod_ff[3]);
         rsp_value_ff  <= rsp_value_in;
         rsp_row_ff    <= s3_meta_ff.row;
         rsp_col_ff    <= s3_meta_ff.col;
         rsp_last_ff   <= s3_meta_ff.last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         xf_ff        <= 1'b0;
         cnt_ff       <= '0;
         left_vld_ff  <= '0;
         right_vld_ff <= '0;
         s1_meta_ff   <= '0;
         s2_meta_ff   <= '0;
         s3_meta_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         xf_ff        <= xf_in;
         cnt_ff       <= cnt_in;
         left_vld_ff  <= left_vld_in;
         right_vld_ff <= right_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            s1_meta_ff <= s1_meta_in;
            s2_meta_ff <= s1_meta_ff;
            s3_meta_ff <= s2_meta_ff;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

`ifndef SYNTHESIS
   // a transform run never counts past its four rows
   a_xf_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && xf_ff) |-> (cnt_ff[m4me_pkg::CNT_W-1:2] == 2'd0))
      else $error("transform counter out of range");

   // a run starts from the first row and column
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && cnt_ff == '0))
      else $error("run did not start at element zero");

   // a load never starts a run
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (load_left || load_right) |=> !busy_ff)
      else $error("load word started a run");

   // the marked word of a run is always its bottom row
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_last) |-> (rsp_out_row == 2'd3))
      else $error("last word not on the final row");
`endif

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the 4x4 Q16.16 matrix multiply engine
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]                 kind;
      logic [m4me_pkg::IDX_W-1:0] row;
      logic [m4me_pkg::IDX_W-1:0] col;
      m4me_pkg::word_type         elem;
      m4me_pkg::word_type         vx;
      m4me_pkg::word_type         vy;
      m4me_pkg::word_type         vz;
      m4me_pkg::word_type         vw;
      int                         pause;
      bit                         drain;
   } cmd_word_type;

   typedef struct {
      logic [m4me_pkg::IDX_W-1:0] row;
      logic [m4me_pkg::IDX_W-1:0] col;
      m4me_pkg::word_type         value;
      logic                       last;
   } elem_word_type;

   localparam m4me_pkg::word_type ONE_Q = 32'sh0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_kind = m4me_pkg::KIND_LOAD_LEFT;
   logic [m4me_pkg::IDX_W-1:0] req_row_sel = '0;
   logic [m4me_pkg::IDX_W-1:0] req_col_sel = '0;
   m4me_pkg::word_type req_element_value = '0;
   m4me_pkg::word_type req_vec_x = '0;
   m4me_pkg::word_type req_vec_y = '0;
   m4me_pkg::word_type req_vec_z = '0;
   m4me_pkg::word_type req_vec_w = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [m4me_pkg::IDX_W-1:0] rsp_out_row;
   logic [m4me_pkg::IDX_W-1:0] rsp_out_col;
   m4me_pkg::word_type rsp_out_value;
   logic rsp_out_last;

   cmd_word_type       pending_words[$];
   elem_word_type      awaited_elems[$];
   m4me_pkg::word_type lhs_store [16];
   m4me_pkg::word_type rhs_store [16];
   cmd_word_type       cur_word;
   int total_words = 0;
   int words_taken = 0;
   int elems_seen = 0;
   int fail_count = 0;
   int tx_mode = 1;
   int rsp_mode = 0;
   int gap_count = 0;
   int stall_left = 0;

   mat4_multiply_engine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_row_sel       (req_row_sel),
      .req_col_sel       (req_col_sel),
      .req_element_value (req_element_value),
      .req_vec_x         (req_vec_x),
      .req_vec_y         (req_vec_y),
      .req_vec_z         (req_vec_z),
      .req_vec_w         (req_vec_w),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_last      (rsp_out_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_pause(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 12)) : 0;
         default: return int'($urandom_range(0, 12));
      endcase
   endfunction

   // full-range values, modest and tiny magnitudes so some sums stay in range, and the extremes
   function automatic m4me_pkg::word_type rand_q();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return m4me_pkg::word_type'($urandom);
         4, 5, 6: return m4me_pkg::word_type'(int'($urandom_range(0, 32'h0010_0000)) -
                                              32'sh0008_0000);
         7: return m4me_pkg::Q_MAX;
         8: return m4me_pkg::Q_MIN;
         default: return m4me_pkg::word_type'(int'($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   // one row of the left matrix against a column, floored to Q16.16 and clamped
   function automatic m4me_pkg::word_type dot_row(input int r,
                                                  input m4me_pkg::word_type b0,
                                                  input m4me_pkg::word_type b1,
                                                  input m4me_pkg::word_type b2,
                                                  input m4me_pkg::word_type b3);
      logic signed [65:0] acc;
      logic signed [65:0] ea;
      logic signed [65:0] eb;
      m4me_pkg::word_type bv [4];
      bv[0] = b0;
      bv[1] = b1;
      bv[2] = b2;
      bv[3] = b3;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         ea = lhs_store[r * 4 + k];
         eb = bv[k];
         acc = acc + ea * eb;
      end
      acc = acc >>> m4me_pkg::FRAC_W;
      if (acc > m4me_pkg::Q_MAX) return m4me_pkg::Q_MAX;
      if (acc < m4me_pkg::Q_MIN) return m4me_pkg::Q_MIN;
      return m4me_pkg::word_type'(acc[m4me_pkg::DATA_W-1:0]);
   endfunction

   function automatic void advance_matrices(input cmd_word_type w);
      elem_word_type e;
      int n;
      n = 0;
      case (w.kind)
         m4me_pkg::KIND_LOAD_LEFT: lhs_store[{w.row, w.col}] = w.elem;
         m4me_pkg::KIND_LOAD_RIGHT: rhs_store[{w.row, w.col}] = w.elem;
         m4me_pkg::KIND_PRODUCT: begin
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 4; c++) begin
                  e.row = m4me_pkg::IDX_W'(r);
                  e.col = m4me_pkg::IDX_W'(c);
                  e.value = dot_row(r, rhs_store[c], rhs_store[4 + c], rhs_store[8 + c],
                                    rhs_store[12 + c]);
                  e.last = (n == 15);
                  awaited_elems.push_back(e);
                  n++;
               end
            end
         end
         default: begin
            for (int r = 0; r < 4; r++) begin
               e.row = m4me_pkg::IDX_W'(r);
               e.col = '0;
               e.value = dot_row(r, w.vx, w.vy, w.vz, w.vw);
               e.last = (r == 3);
               awaited_elems.push_back(e);
            end
         end
      endcase
   endfunction

   task automatic add_word(input logic [1:0] kind, input logic [m4me_pkg::IDX_W-1:0] row,
                           input logic [m4me_pkg::IDX_W-1:0] col,
                           input m4me_pkg::word_type elem,
                           input m4me_pkg::word_type vx, input m4me_pkg::word_type vy,
                           input m4me_pkg::word_type vz, input m4me_pkg::word_type vw,
                           input bit drain);
      cmd_word_type w;
      w.kind = kind;
      w.row = row;
      w.col = col;
      w.elem = elem;
      w.vx = vx;
      w.vy = vy;
      w.vz = vz;
      w.vw = vw;
      w.pause = draw_pause(tx_mode);
      w.drain = drain;
      pending_words.push_back(w);
      total_words++;
   endtask

   // driver: a new word goes out once its gap has elapsed and, if flagged, the engine has drained
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            advance_matrices(cur_word);
            words_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && gap_count >= pending_words[0].pause &&
                (!pending_words[0].drain || awaited_elems.size() == 0)) begin
               cur_word = pending_words.pop_front();
               gap_count = 0;
               req_valid <= 1'b1;
               req_kind <= cur_word.kind;
               req_row_sel <= cur_word.row;
               req_col_sel <= cur_word.col;
               req_element_value <= cur_word.elem;
               req_vec_x <= cur_word.vx;
               req_vec_y <= cur_word.vy;
               req_vec_z <= cur_word.vz;
               req_vec_w <= cur_word.vw;
            end else begin
               req_valid <= 1'b0;
               if (pending_words.size() != 0 && gap_count < pending_words[0].pause)
                  gap_count++;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest one awaited, stall ready at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (rsp_valid && rsp_ready) begin
         if (awaited_elems.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected result word: row %0d col %0d value %h last %b",
                        rsp_out_row, rsp_out_col, rsp_out_value, rsp_out_last);
            fail_count++;
         end else begin
            elem_word_type e;
            e = awaited_elems.pop_front();
            if (rsp_out_row !== e.row || rsp_out_col !== e.col ||
                rsp_out_value !== e.value || rsp_out_last !== e.last) begin
               if (fail_count < 10)
                  $display("mismatch %0d: exp r%0d c%0d %h l%b, got r%0d c%0d %h l%b",
                           elems_seen, e.row, e.col, e.value, e.last,
                           rsp_out_row, rsp_out_col, rsp_out_value, rsp_out_last);
               fail_count++;
            end
         end
         elems_seen++;
         if (elems_seen % 48 == 0)
            rsp_mode = $urandom_range(0, 2);
         stall_left = draw_pause(rsp_mode);
         if (stall_left != 0)
            rsp_ready <= 1'b0;
      end else if (!rsp_ready) begin
         if (stall_left <= 1) begin
            rsp_ready <= 1'b1;
            stall_left = 0;
         end else begin
            stall_left--;
         end
      end
   end

   initial begin
      int settle;
      int nloads;
      logic [1:0] op;
      for (int i = 0; i < 16; i++) begin
         lhs_store[i] = '0;
         rhs_store[i] = '0;
      end

      // matrices straight out of reset
      add_word(m4me_pkg::KIND_PRODUCT, 2'd3, 2'd3, m4me_pkg::Q_MIN, m4me_pkg::Q_MAX,
               m4me_pkg::Q_MIN, m4me_pkg::Q_MAX, m4me_pkg::Q_MIN, 1'b0);
      add_word(m4me_pkg::KIND_TRANSFORM, 2'd0, 2'd0, m4me_pkg::Q_MAX, m4me_pkg::Q_MAX,
               m4me_pkg::Q_MIN, m4me_pkg::Q_MAX, m4me_pkg::Q_MIN, 1'b0);
      // full-scale row and column so the sums clamp both ways
      for (int i = 0; i < 4; i++)
         add_word(m4me_pkg::KIND_LOAD_LEFT, 2'd0, m4me_pkg::IDX_W'(i), m4me_pkg::Q_MAX,
                  '0, '0, '0, '0, 1'b0);
      for (int i = 0; i < 4; i++)
         add_word(m4me_pkg::KIND_LOAD_RIGHT, m4me_pkg::IDX_W'(i), 2'd0, m4me_pkg::Q_MAX,
                  '0, '0, '0, '0, 1'b0);
      add_word(m4me_pkg::KIND_PRODUCT, 2'd0, 2'd0, '0, '0, '0, '0, '0, 1'b0);
      add_word(m4me_pkg::KIND_TRANSFORM, 2'd0, 2'd0, '0, m4me_pkg::Q_MIN, m4me_pkg::Q_MIN,
               m4me_pkg::Q_MIN, m4me_pkg::Q_MIN, 1'b0);
      add_word(m4me_pkg::KIND_TRANSFORM, 2'd0, 2'd0, '0, m4me_pkg::Q_MAX, m4me_pkg::Q_MAX,
               m4me_pkg::Q_MAX, m4me_pkg::Q_MAX, 1'b0);
      // small negative product floors towards minus infinity
      add_word(m4me_pkg::KIND_LOAD_LEFT, 2'd3, 2'd3, -32'sd1, '0, '0, '0, '0, 1'b0);
      add_word(m4me_pkg::KIND_TRANSFORM, 2'd0, 2'd0, '0, '0, '0, '0, 32'sd1, 1'b0);
      add_word(m4me_pkg::KIND_LOAD_LEFT, 2'd3, 2'd0, m4me_pkg::Q_MIN, '0, '0, '0, '0, 1'b0);
      add_word(m4me_pkg::KIND_LOAD_RIGHT, 2'd0, 2'd3, m4me_pkg::Q_MIN, '0, '0, '0, '0, 1'b0);
      add_word(m4me_pkg::KIND_PRODUCT, 2'd1, 2'd2, m4me_pkg::Q_MAX, '0, '0, '0, '0, 1'b0);
      // ordinary in-range values
      add_word(m4me_pkg::KIND_LOAD_RIGHT, 2'd1, 2'd2, ONE_Q, '0, '0, '0, '0, 1'b0);
      add_word(m4me_pkg::KIND_LOAD_LEFT, 2'd2, 2'd1, 32'sh0003_8000, '0, '0, '0, '0, 1'b0);
      add_word(m4me_pkg::KIND_TRANSFORM, 2'd0, 2'd0, '0, ONE_Q, -32'sh0002_0000,
               32'sh0000_8000, -32'sh0000_0003, 1'b0);
      // held back until every earlier result has come out
      add_word(m4me_pkg::KIND_PRODUCT, 2'd0, 2'd0, '0, '0, '0, '0, '0, 1'b1);

      // random part: runs of loads closed by a product or transform, plus full-matrix loads and noise words
      while (total_words < 300) begin
         if ($urandom_range(0, 5) == 0)
            tx_mode = $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            0: add_word(2'($urandom), 2'($urandom), 2'($urandom),
                        m4me_pkg::word_type'($urandom), m4me_pkg::word_type'($urandom),
                        m4me_pkg::word_type'($urandom), m4me_pkg::word_type'($urandom),
                        m4me_pkg::word_type'($urandom), $urandom_range(0, 30) == 0);
            1: begin
               op = $urandom_range(0, 1) ? m4me_pkg::KIND_LOAD_RIGHT
                                         : m4me_pkg::KIND_LOAD_LEFT;
               for (int i = 0; i < 16; i++)
                  add_word(op, m4me_pkg::IDX_W'(i / 4), m4me_pkg::IDX_W'(i % 4), rand_q(),
                           '0, '0, '0, '0, 1'b0);
            end
            default: begin
               nloads = $urandom_range(1, 10);
               for (int i = 0; i < nloads; i++)
                  add_word($urandom_range(0, 1) ? m4me_pkg::KIND_LOAD_RIGHT
                                                : m4me_pkg::KIND_LOAD_LEFT,
                           2'($urandom), 2'($urandom), rand_q(),
                           m4me_pkg::word_type'($urandom), m4me_pkg::word_type'($urandom),
                           m4me_pkg::word_type'($urandom), m4me_pkg::word_type'($urandom),
                           1'b0);
               op = $urandom_range(0, 1) ? m4me_pkg::KIND_TRANSFORM : m4me_pkg::KIND_PRODUCT;
               add_word(op, 2'($urandom), 2'($urandom), m4me_pkg::word_type'($urandom),
                        rand_q(), rand_q(), rand_q(), rand_q(), $urandom_range(0, 30) == 0);
            end
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (words_taken < total_words)
         @(negedge clock);
      settle = 0;
      while (awaited_elems.size() != 0 && settle < 20000) begin
         @(negedge clock);
         settle++;
      end
      repeat (40) @(negedge clock);
      if (awaited_elems.size() != 0) begin
         $display("%0d result words never arrived", awaited_elems.size());
         fail_count += awaited_elems.size();
      end
      if (fail_count == 0) begin
         $display("** mat4_multiply_engine: PASSED **");
      end else begin
         $display("** mat4_multiply_engine: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d of %0d words taken", words_taken, total_words);
      $display("** mat4_multiply_engine: FAILED **");
      $finish;
   end

endmodule

// File: mat4_multiply_engine.f
hdl/m4me_pkg.sv
hdl/mat4_multiply_engine.sv
verif/tb_top.sv
